// ===== design/atw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atw_pkg
// Types, codes and tables shared by the text terminal writer and its channels.
// ----------------------------------------------------------------------------
package atw_pkg;

    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_PARAMS  = 16;
    localparam int DEF_TAB_STOP    = 4;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] CFG_DEFAULT_ATTR = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_COLS  = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_ROWS  = 2'd2;
    localparam logic [1:0] CFG_ADD_CR       = 2'd3;

    localparam logic [7:0] RST_DEFAULT_ATTR = 8'd7;
    localparam logic [7:0] RST_ACTIVE_COLS  = 8'd80;
    localparam logic [6:0] RST_ACTIVE_ROWS  = 7'd25;
    localparam logic       RST_ADD_CR       = 1'b1;
    localparam logic [7:0] ATTR_RESET       = 8'h07;

    localparam logic [7:0] ATTR_BRIGHT  = 8'h08;
    localparam logic [7:0] ATTR_BG_MASK = 8'hF0;
    localparam logic [7:0] ATTR_FG_MASK = 8'h0F;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;

    localparam logic [7:0] CMD_UP    = 8'h41;
    localparam logic [7:0] CMD_DOWN  = 8'h42;
    localparam logic [7:0] CMD_RIGHT = 8'h43;
    localparam logic [7:0] CMD_LEFT  = 8'h44;
    localparam logic [7:0] CMD_POS   = 8'h48;
    localparam logic [7:0] CMD_POS_F = 8'h66;
    localparam logic [7:0] CMD_ED    = 8'h4A;
    localparam logic [7:0] CMD_EL    = 8'h4B;
    localparam logic [7:0] CMD_SGR   = 8'h6D;

    localparam logic [15:0] ED_ALL   = 16'd2;
    localparam logic [15:0] EL_RIGHT = 16'd0;
    localparam logic [15:0] EL_LEFT  = 16'd1;

    localparam logic [15:0] SGR_RESET   = 16'd0;
    localparam logic [15:0] SGR_BOLD    = 16'd1;
    localparam logic [15:0] SGR_FG_LO   = 16'd30;
    localparam logic [15:0] SGR_FG_HI   = 16'd37;
    localparam logic [15:0] SGR_BG_LO   = 16'd40;
    localparam logic [15:0] SGR_BG_HI   = 16'd47;
    localparam logic [15:0] SGR_FGB_LO  = 16'd90;
    localparam logic [15:0] SGR_FGB_HI  = 16'd97;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_CSI
    } t_phase;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_CHAR,
        S_COPY,
        S_CPW,
        S_FILL,
        S_SGR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_col;
        logic [5:0]  cursor_row;
        logic [7:0]  current_attr;
    } t_out_item;

    typedef struct packed {
        logic [1:0] reg_index;
        logic [7:0] wdata;
    } t_cfg_item;

    function automatic logic [3:0] fg_color(input logic [2:0] idx);
        logic [3:0] c;
        case (idx)
            3'd0:    c = 4'h0;
            3'd1:    c = 4'h4;
            3'd2:    c = 4'h2;
            3'd3:    c = 4'h6;
            3'd4:    c = 4'h1;
            3'd5:    c = 4'h5;
            3'd6:    c = 4'h3;
            default: c = 4'h7;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sgr_apply(input logic [7:0] attr, input logic [7:0] dflt,
                                             input logic [15:0] code);
        logic [7:0]  a;
        logic [15:0] d;
        a = attr;
        d = '0;
        case (code) inside
            SGR_RESET: a = dflt;
            SGR_BOLD:  a = attr | ATTR_BRIGHT;
            [SGR_FG_LO:SGR_FG_HI]: begin
                d = code - SGR_FG_LO;
                a = (attr & ATTR_BG_MASK) | {4'h0, fg_color(d[2:0])};
            end
            [SGR_BG_LO:SGR_BG_HI]: begin
                d = code - SGR_BG_LO;
                a = (attr & ATTR_FG_MASK) | {fg_color(d[2:0]), 4'h0};
            end
            [SGR_FGB_LO:SGR_FGB_HI]: begin
                d = code - SGR_FGB_LO;
                a = (attr & ATTR_BG_MASK) | {4'h0, fg_color(d[2:0])} | ATTR_BRIGHT;
            end
            default: a = attr;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== design/atw_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atw_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface atw_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/ansi_text_terminal_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_text_terminal_writer
// Character-cell terminal with an ESC [ sequence parser and a cell memory.
//
// i_in takes one item: put byte, read cell or clear screen. o_out gives one
// item per input item: cell read (zero for other ops), cursor and attribute.
// i_cfg writes the mode registers; it is always ready and is to be used only
// while no item is in flight.
// Work per item, on the cell memory (one write port and one read port):
//   bytes absorbed by the parser, CR, moves, H/f: no memory access
//   printable byte: one cell written; cell read: one cell read; tab:
//   spaces written up to the next tab stop; backspace: rest of row shifted
//   left; erase line: span blanked; SGR: parameters applied one by one
//   scroll on line feed or wrap: active rows copied up, last row blanked
//   clear screen: all MAX_ROWS * MAX_COLUMNS cells blanked
// After reset the memory is swept to empty, all MAX_ROWS * MAX_COLUMNS cells
// (8192 at the defaults), and i_in is not ready during the sweep.
// A result waits in an output register; if o_out stalls, the next item is
// still taken and held at its end until the register frees.
// ----------------------------------------------------------------------------
module ansi_text_terminal_writer #(
    parameter int MAX_COLUMNS = atw_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = atw_pkg::DEF_MAX_ROWS,
    parameter int MAX_PARAMS  = atw_pkg::DEF_MAX_PARAMS,
    parameter int TAB_STOP    = atw_pkg::DEF_TAB_STOP
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    atw_stream_if.sink          i_in,
    atw_stream_if.source        o_out,
    atw_stream_if.sink          i_cfg
);

    localparam int MC    = MAX_COLUMNS;
    localparam int MR    = MAX_ROWS;
    localparam int DEPTH = MC * MR;
    localparam int A_W   = $clog2(DEPTH);
    localparam int AE_W  = A_W + 1;
    localparam int X_W   = $clog2(MC);
    localparam int Y_W   = $clog2(MR);
    localparam int C_W   = $clog2(MC + 1);
    localparam int R_W   = $clog2(MR + 1);
    localparam int K_W   = $clog2(MAX_PARAMS);
    localparam int PI_W  = $clog2(MAX_PARAMS + 1);
    localparam int T_W   = $clog2(TAB_STOP + 1);

    logic [15:0] r_screen [DEPTH];
    logic [15:0] r_rdata;
    logic        mem_we;
    logic [A_W-1:0] mem_waddr, mem_raddr;
    logic [15:0] mem_wdata;

    logic [T_W-1:0] tab_tbl [MC];

    atw_pkg::t_state r_state, n_state;
    atw_pkg::t_phase r_phase, n_phase;
    logic [X_W-1:0]  r_x, n_x;
    logic [Y_W-1:0]  r_y, n_y;
    logic [7:0]      r_attr, n_attr;
    logic [PI_W-1:0] r_pidx, n_pidx;
    logic [15:0]     r_params [MAX_PARAMS];
    logic            par_we;
    logic [K_W-1:0]  par_widx;
    logic [15:0]     par_wdata;

    logic [7:0] r_cfg_attr;
    logic [7:0] r_cfg_cols;
    logic [6:0] r_cfg_rows;
    logic       r_cfg_addcr;

    logic [A_W-1:0] r_ptr, n_ptr, r_last, n_last, r_off, n_off;
    logic [A_W-1:0] r_flo, n_flo, r_fhi, n_fhi, r_cp_dst, n_cp_dst;
    logic           r_cp_v, n_cp_v;
    logic [T_W-1:0] r_tab, n_tab;
    logic [7:0]     r_ch, n_ch;
    logic [K_W-1:0] r_sgr_i, n_sgr_i, r_sgr_last, n_sgr_last;
    logic           r_oob, n_oob;
    logic [15:0]    r_cell, n_cell;
    logic           r_out_valid;
    atw_pkg::t_out_item r_out;

    logic [C_W-1:0] cols;
    logic [R_W-1:0] rows;
    logic [X_W-1:0] xlast, xc;
    logic [Y_W-1:0] ylast, yc, ysel;
    logic [A_W-1:0] row_base, scr_end, scr_lo, xlast_a;
    logic [K_W-1:0] kidx, rd_idx;
    logic [15:0]    pv, p0, p1, hc;
    logic [16:0]    n17, sum_y, sum_x;
    logic [Y_W-1:0] up_y, dn_y, hy;
    logic [X_W-1:0] lf_x, rt_x, hx;
    logic [19:0]    prod;
    logic [PI_W:0]  psum;
    logic [7:0]     ch;
    logic           fin, slot_free, out_load;

    genvar g;
    generate
        for (g = 0; g < MC; g++) begin : g_tab
            assign tab_tbl[g] = T_W'(TAB_STOP - (g % TAB_STOP));
        end
    endgenerate

    always_comb begin
        if (r_cfg_cols == '0) begin
            cols = C_W'(1);
        end else if ({1'b0, r_cfg_cols} > 9'(MC)) begin
            cols = C_W'(MC);
        end else begin
            cols = C_W'(r_cfg_cols);
        end
        if (r_cfg_rows == '0) begin
            rows = R_W'(1);
        end else if ({1'b0, r_cfg_rows} > 8'(MR)) begin
            rows = R_W'(MR);
        end else begin
            rows = R_W'(r_cfg_rows);
        end
    end

    assign xlast   = X_W'(cols - 1'b1);
    assign ylast   = Y_W'(rows - 1'b1);
    assign xlast_a = A_W'(xlast);
    assign xc      = (C_W'(r_x) >= cols) ? xlast : r_x;
    assign yc      = (R_W'(r_y) >= rows) ? ylast : r_y;
    assign scr_end = A_W'(AE_W'(rows) * AE_W'(MC) - AE_W'(1));
    assign scr_lo  = scr_end - A_W'(MC - 1);
    assign kidx    = (r_pidx < PI_W'(MAX_PARAMS)) ? K_W'(r_pidx) : K_W'(MAX_PARAMS - 1);
    assign p0      = r_params[0];
    assign p1      = r_params[1];
    assign ch      = i_in.data.char_code;
    assign slot_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == atw_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n17   = (p0 == '0) ? 17'd1 : {1'b0, p0};
        up_y  = (17'(yc) < n17) ? '0 : Y_W'(17'(yc) - n17);
        sum_y = 17'(yc) + n17;
        dn_y  = (sum_y >= 17'(rows)) ? ylast : Y_W'(sum_y);
        lf_x  = (17'(xc) < n17) ? '0 : X_W'(17'(xc) - n17);
        sum_x = 17'(xc) + n17;
        rt_x  = (sum_x >= 17'(cols)) ? xlast : X_W'(sum_x);
        hy    = (p0 == '0) ? '0
              : ((17'(p0 - 16'd1) >= 17'(rows)) ? ylast : Y_W'(p0 - 16'd1));
        hc    = (kidx != '0) ? p1 : 16'd1;
        hx    = (hc == '0) ? '0
              : ((17'(hc - 16'd1) >= 17'(cols)) ? xlast : X_W'(hc - 16'd1));
    end

    always_comb begin
        n_state = r_state;   n_phase = r_phase;  n_x = r_x;      n_y = r_y;
        n_attr = r_attr;     n_pidx = r_pidx;    n_ptr = r_ptr;  n_last = r_last;
        n_off = r_off;       n_flo = r_flo;      n_fhi = r_fhi;  n_cp_dst = r_cp_dst;
        n_cp_v = 1'b0;       n_tab = r_tab;      n_ch = r_ch;    n_sgr_i = r_sgr_i;
        n_sgr_last = r_sgr_last;  n_oob = r_oob; n_cell = '0;
        mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_raddr = '0;
        par_we = 1'b0;  par_widx = '0;   par_wdata = '0;
        fin = 1'b0;     out_load = 1'b0;
        ysel     = (r_state == atw_pkg::S_IDLE) ? yc : r_y;
        row_base = A_W'(AE_W'(ysel) * AE_W'(MC));
        rd_idx   = (r_state == atw_pkg::S_SGR) ? r_sgr_i : kidx;
        pv       = r_params[rd_idx];
        prod     = 20'(pv) * 20'd10 + 20'(ch[3:0]);
        psum     = (PI_W + 1)'(r_pidx) + (PI_W + 1)'(1);

        case (r_state)
            atw_pkg::S_INIT: begin
                mem_we = 1'b1;
                mem_waddr = r_ptr;
                if (r_ptr == A_W'(DEPTH - 1)) begin
                    n_state = atw_pkg::S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            atw_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_x = xc;
                    n_y = yc;
                    case (i_in.data.op)
                        atw_pkg::OP_READ: begin
                            n_oob = !((int'(i_in.data.read_row) < MR)
                                      && (int'(i_in.data.read_col) < MC));
                            mem_raddr = A_W'(AE_W'(i_in.data.read_row) * AE_W'(MC)
                                             + AE_W'(i_in.data.read_col));
                            n_state = atw_pkg::S_RD;
                        end
                        atw_pkg::OP_CLEAR: begin
                            n_x = '0;
                            n_y = '0;
                            n_tab = '0;
                            n_ptr = '0;
                            n_last = A_W'(DEPTH - 1);
                            n_state = atw_pkg::S_FILL;
                        end
                        atw_pkg::OP_PUT: begin
                            if ((ch == atw_pkg::CH_LF && r_cfg_addcr)
                                || (ch == atw_pkg::CH_LF && r_phase == atw_pkg::PH_TEXT)) begin
                                n_phase = atw_pkg::PH_TEXT;
                                n_x = '0;
                                n_tab = '0;
                                if (R_W'(yc) + 1'b1 >= rows) begin
                                    n_y = ylast;
                                    if (rows == R_W'(1)) begin
                                        n_ptr = '0;
                                        n_last = A_W'(MC - 1);
                                        n_state = atw_pkg::S_FILL;
                                    end else begin
                                        n_ptr = A_W'(MC);
                                        n_last = scr_end;
                                        n_off = A_W'(MC);
                                        n_flo = scr_lo;
                                        n_fhi = scr_end;
                                        n_state = atw_pkg::S_COPY;
                                    end
                                end else begin
                                    n_y = yc + 1'b1;
                                    fin = 1'b1;
                                end
                            end else if (r_phase == atw_pkg::PH_ESC) begin
                                fin = 1'b1;
                                if (ch == atw_pkg::CH_LBRK) begin
                                    n_phase = atw_pkg::PH_CSI;
                                    n_pidx = '0;
                                    par_we = 1'b1;
                                    par_widx = '0;
                                end else begin
                                    n_phase = atw_pkg::PH_TEXT;
                                end
                            end else if (r_phase == atw_pkg::PH_CSI) begin
                                fin = 1'b1;
                                if (ch inside {[8'h30:8'h39]}) begin
                                    par_we = 1'b1;
                                    par_widx = kidx;
                                    par_wdata = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
                                end else if (ch == atw_pkg::CH_SEMI) begin
                                    par_we = 1'b1;
                                    if (psum >= (PI_W + 1)'(MAX_PARAMS)) begin
                                        n_pidx = PI_W'(MAX_PARAMS - 1);
                                        par_widx = K_W'(MAX_PARAMS - 1);
                                    end else begin
                                        n_pidx = PI_W'(psum);
                                        par_widx = K_W'(psum);
                                    end
                                end else if (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
                                    n_phase = atw_pkg::PH_TEXT;
                                    n_pidx = PI_W'(kidx) + PI_W'(1);
                                    n_tab = '0;
                                    case (ch)
                                        atw_pkg::CMD_UP:    n_y = up_y;
                                        atw_pkg::CMD_DOWN:  n_y = dn_y;
                                        atw_pkg::CMD_RIGHT: n_x = rt_x;
                                        atw_pkg::CMD_LEFT:  n_x = lf_x;
                                        atw_pkg::CMD_POS, atw_pkg::CMD_POS_F: begin
                                            n_y = hy;
                                            n_x = hx;
                                        end
                                        atw_pkg::CMD_ED: begin
                                            if (p0 == atw_pkg::ED_ALL) begin
                                                fin = 1'b0;
                                                n_x = '0;
                                                n_y = '0;
                                                n_ptr = '0;
                                                n_last = A_W'(DEPTH - 1);
                                                n_state = atw_pkg::S_FILL;
                                            end
                                        end
                                        atw_pkg::CMD_EL: begin
                                            fin = 1'b0;
                                            n_state = atw_pkg::S_FILL;
                                            if (p0 == atw_pkg::EL_RIGHT) begin
                                                n_ptr = row_base + A_W'(xc);
                                                n_last = row_base + xlast_a;
                                            end else if (p0 == atw_pkg::EL_LEFT) begin
                                                n_ptr = row_base;
                                                n_last = row_base + A_W'(xc);
                                            end else begin
                                                n_ptr = row_base;
                                                n_last = row_base + xlast_a;
                                            end
                                        end
                                        atw_pkg::CMD_SGR: begin
                                            fin = 1'b0;
                                            n_sgr_i = '0;
                                            n_sgr_last = kidx;
                                            n_state = atw_pkg::S_SGR;
                                        end
                                        default: ;
                                    endcase
                                end else if (ch != atw_pkg::CH_QMARK) begin
                                    n_phase = atw_pkg::PH_TEXT;
                                end
                            end else begin
                                n_phase = atw_pkg::PH_TEXT;
                                if (ch == atw_pkg::CH_ESC) begin
                                    n_phase = atw_pkg::PH_ESC;
                                    fin = 1'b1;
                                end else if (ch == atw_pkg::CH_CR) begin
                                    n_x = '0;
                                    fin = 1'b1;
                                end else if (ch == atw_pkg::CH_TAB) begin
                                    n_tab = tab_tbl[xc];
                                    n_ch = atw_pkg::CH_SP;
                                    n_state = atw_pkg::S_CHAR;
                                end else if (ch == atw_pkg::CH_BS) begin
                                    if (xc != '0) begin
                                        n_x = xc - 1'b1;
                                        n_tab = '0;
                                        n_ptr = row_base + A_W'(xc);
                                        n_last = row_base + xlast_a;
                                        n_off = A_W'(1);
                                        n_flo = row_base + xlast_a;
                                        n_fhi = row_base + xlast_a;
                                        n_state = atw_pkg::S_COPY;
                                    end else begin
                                        fin = 1'b1;
                                    end
                                end else begin
                                    n_tab = T_W'(1);
                                    n_ch = ch;
                                    n_state = atw_pkg::S_CHAR;
                                end
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            atw_pkg::S_RD: begin
                n_cell = (r_oob || r_rdata == '0) ? {r_attr, atw_pkg::CH_SP} : r_rdata;
                fin = 1'b1;
            end
            atw_pkg::S_CHAR: begin
                mem_we = 1'b1;
                mem_waddr = row_base + A_W'(r_x);
                mem_wdata = {r_attr, r_ch};
                n_tab = r_tab - 1'b1;
                if (C_W'(r_x) + 1'b1 >= cols) begin
                    n_x = '0;
                    if (R_W'(r_y) + 1'b1 >= rows) begin
                        n_y = ylast;
                        if (rows == R_W'(1)) begin
                            n_ptr = '0;
                            n_last = A_W'(MC - 1);
                            n_state = atw_pkg::S_FILL;
                        end else begin
                            n_ptr = A_W'(MC);
                            n_last = scr_end;
                            n_off = A_W'(MC);
                            n_flo = scr_lo;
                            n_fhi = scr_end;
                            n_state = atw_pkg::S_COPY;
                        end
                    end else begin
                        n_y = r_y + 1'b1;
                        fin = (n_tab == '0);
                    end
                end else begin
                    n_x = r_x + 1'b1;
                    fin = (n_tab == '0);
                end
            end
            atw_pkg::S_COPY: begin
                mem_raddr = r_ptr;
                n_cp_v = 1'b1;
                n_cp_dst = r_ptr - r_off;
                mem_we = r_cp_v;
                mem_waddr = r_cp_dst;
                mem_wdata = r_rdata;
                if (r_ptr == r_last) begin
                    n_state = atw_pkg::S_CPW;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            atw_pkg::S_CPW: begin
                mem_we = 1'b1;
                mem_waddr = r_cp_dst;
                mem_wdata = r_rdata;
                n_ptr = r_flo;
                n_last = r_fhi;
                n_state = atw_pkg::S_FILL;
            end
            atw_pkg::S_FILL: begin
                mem_we = 1'b1;
                mem_waddr = r_ptr;
                if (r_ptr == r_last) begin
                    if (r_tab != '0) begin
                        n_state = atw_pkg::S_CHAR;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            atw_pkg::S_SGR: begin
                n_attr = atw_pkg::sgr_apply(r_attr, r_cfg_attr, pv);
                if (r_sgr_i == r_sgr_last) begin
                    fin = 1'b1;
                end else begin
                    n_sgr_i = r_sgr_i + 1'b1;
                end
            end
            atw_pkg::S_DONE: begin
                n_cell = r_cell;
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state = atw_pkg::S_IDLE;
                end
            end
            default: n_state = atw_pkg::S_IDLE;
        endcase

        if (fin) begin
            if (slot_free) begin
                out_load = 1'b1;
                n_state = atw_pkg::S_IDLE;
            end else begin
                n_state = atw_pkg::S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_screen[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atw_pkg::S_INIT;
            r_phase     <= atw_pkg::PH_TEXT;
            r_x         <= '0;
            r_y         <= '0;
            r_attr      <= atw_pkg::ATTR_RESET;
            r_pidx      <= '0;
            for (int i = 0; i < MAX_PARAMS; i++) begin
                r_params[i] <= '0;
            end
            r_cfg_attr  <= atw_pkg::RST_DEFAULT_ATTR;
            r_cfg_cols  <= atw_pkg::RST_ACTIVE_COLS;
            r_cfg_rows  <= atw_pkg::RST_ACTIVE_ROWS;
            r_cfg_addcr <= atw_pkg::RST_ADD_CR;
            r_ptr       <= '0;
            r_tab       <= '0;
            r_cp_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_x     <= n_x;
            r_y     <= n_y;
            r_attr  <= n_attr;
            r_pidx  <= n_pidx;
            if (par_we) begin
                r_params[par_widx] <= par_wdata;
            end
            if (i_cfg.valid) begin
                case (i_cfg.data.reg_index)
                    atw_pkg::CFG_DEFAULT_ATTR: r_cfg_attr  <= i_cfg.data.wdata;
                    atw_pkg::CFG_ACTIVE_COLS:  r_cfg_cols  <= i_cfg.data.wdata;
                    atw_pkg::CFG_ACTIVE_ROWS:  r_cfg_rows  <= i_cfg.data.wdata[6:0];
                    atw_pkg::CFG_ADD_CR:       r_cfg_addcr <= i_cfg.data.wdata[0];
                    default: ;
                endcase
            end
            r_ptr  <= n_ptr;
            r_tab  <= n_tab;
            r_cp_v <= n_cp_v;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_off      <= n_off;
        r_flo      <= n_flo;
        r_fhi      <= n_fhi;
        r_cp_dst   <= n_cp_dst;
        r_ch       <= n_ch;
        r_sgr_i    <= n_sgr_i;
        r_sgr_last <= n_sgr_last;
        r_oob      <= n_oob;
        r_cell     <= n_cell;
        if (out_load) begin
            r_out.cell_value   <= n_cell;
            r_out.cursor_col   <= 7'(n_x);
            r_out.cursor_row   <= 6'(n_y);
            r_out.current_attr <= n_attr;
        end
    end

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != atw_pkg::S_IDLE || r_out_valid))
        else $error("accepted item left no work and no result");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atw_pkg::S_IDLE) |-> !mem_we)
        else $error("cell memory written while idle");

    a_copy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atw_pkg::S_COPY) |-> (r_ptr <= r_last))
        else $error("copy pointer past end of range");

    a_pidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pidx <= PI_W'(MAX_PARAMS))
        else $error("parameter index out of range");

    a_drain_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atw_pkg::S_CPW) |-> r_cp_v)
        else $error("copy drain without pending read");

endmodule
`default_nettype wire

// ===== tb/tb_ansi_text_terminal_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ansi_text_terminal_writer
// Self-checking bench for the text terminal writer. A queue-fed driver sends
// put, read, clear and spare-op items, including well-formed and broken
// escape sequences, across several screen modes. A built-in screen predictor
// forms the expected cell, cursor and attribute of each item, and a monitor
// compares every result field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_ansi_text_terminal_writer;
    import atw_pkg::*;

    localparam int NCOL       = DEF_MAX_COLUMNS;
    localparam int NROW       = DEF_MAX_ROWS;
    localparam int NPRM       = DEF_MAX_PARAMS;
    localparam int TABW       = DEF_TAB_STOP;
    localparam int STALL_MAX  = 30000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;

    atw_stream_if #(.t_payload(t_in_item))  in_if ();
    atw_stream_if #(.t_payload(t_out_item)) out_if ();
    atw_stream_if #(.t_payload(t_cfg_item)) cfg_if ();

    ansi_text_terminal_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // screen predictor state
    logic [15:0] scr [0:NROW-1][0:NCOL-1];
    int          cur_x, cur_y;
    logic [7:0]  attr;
    int          esc_phase, prm_idx;
    int          prm [0:NPRM-1];
    logic [7:0]  mode_attr, mode_cols;
    logic [6:0]  mode_rows;
    logic        mode_cr;
    logic [3:0]  fg_tab [0:7] = '{4'h0, 4'h4, 4'h2, 4'h6, 4'h1, 4'h5, 4'h3, 4'h7};

    t_in_item  item_q [$];
    t_cfg_item cfg_q [$];
    t_out_item exp_q [$];
    int        fail_cnt;
    int        send_idle, recv_idle;
    int        stall_cnt;

    function automatic int cols_now();
        return mode_cols < 1 ? 1 : (mode_cols > NCOL ? NCOL : int'(mode_cols));
    endfunction

    function automatic int rows_now();
        return mode_rows < 1 ? 1 : (mode_rows > NROW ? NROW : int'(mode_rows));
    endfunction

    function automatic void wipe_screen();
        for (int r = 0; r < NROW; r++)
            for (int c = 0; c < NCOL; c++) scr[r][c] = '0;
        cur_x = 0;
        cur_y = 0;
    endfunction

    function automatic void next_line();
        int rows;
        rows = rows_now();
        cur_x = 0;
        cur_y++;
        if (cur_y >= rows) begin
            for (int r = 0; r < rows - 1; r++) scr[r] = scr[r + 1];
            for (int c = 0; c < NCOL; c++) scr[rows - 1][c] = '0;
            cur_y = rows - 1;
        end
    endfunction

    function automatic void put_glyph(logic [7:0] c);
        scr[cur_y][cur_x] = {attr, c};
        cur_x++;
        if (cur_x >= cols_now()) next_line();
    endfunction

    function automatic void set_colors();
        int code;
        for (int i = 0; i < prm_idx && i < NPRM; i++) begin
            code = prm[i];
            if (code == 0) attr = mode_attr;
            else if (code == 1) attr = attr | ATTR_BRIGHT;
            else if (code >= 30 && code <= 37) attr = (attr & ATTR_BG_MASK) | fg_tab[code - 30];
            else if (code >= 40 && code <= 47)
                attr = (attr & ATTR_FG_MASK) | {fg_tab[code - 40], 4'h0};
            else if (code >= 90 && code <= 97)
                attr = (attr & ATTR_BG_MASK) | fg_tab[code - 90] | ATTR_BRIGHT;
        end
    endfunction

    function automatic void do_command(logic [7:0] cmd);
        int cols, rows, p0, n, r, c;
        cols = cols_now();
        rows = rows_now();
        p0 = prm[0];
        n = p0 < 1 ? 1 : p0;
        case (cmd)
            CMD_UP: cur_y = cur_y - n < 0 ? 0 : cur_y - n;
            CMD_DOWN: cur_y = cur_y + n >= rows ? rows - 1 : cur_y + n;
            CMD_RIGHT: cur_x = cur_x + n >= cols ? cols - 1 : cur_x + n;
            CMD_LEFT: cur_x = cur_x - n < 0 ? 0 : cur_x - n;
            CMD_POS, CMD_POS_F: begin
                r = p0 < 1 ? 1 : p0;
                c = prm_idx > 1 ? prm[1] : 1;
                if (c < 1) c = 1;
                cur_y = r - 1 >= rows ? rows - 1 : r - 1;
                cur_x = c - 1 >= cols ? cols - 1 : c - 1;
            end
            CMD_ED: if (n == ED_ALL) wipe_screen();
            CMD_EL: begin
                if (p0 == EL_RIGHT) begin
                    for (int i = cur_x; i < cols; i++) scr[cur_y][i] = '0;
                end else if (p0 == EL_LEFT) begin
                    for (int i = 0; i <= cur_x; i++) scr[cur_y][i] = '0;
                end else begin
                    for (int i = 0; i < cols; i++) scr[cur_y][i] = '0;
                end
            end
            CMD_SGR: set_colors();
            default: ;
        endcase
    endfunction

    function automatic bit take_escape(logic [7:0] c);
        int k, v;
        k = prm_idx < NPRM ? prm_idx : NPRM - 1;
        if (esc_phase == PH_ESC) begin
            if (c == CH_LBRK) begin
                esc_phase = PH_CSI;
                prm_idx = 0;
                prm[0] = 0;
            end else begin
                esc_phase = PH_TEXT;
            end
            return 1;
        end
        if (esc_phase == PH_CSI) begin
            if (c >= "0" && c <= "9") begin
                v = prm[k] * 10 + (c - "0");
                prm[k] = v > 65535 ? 65535 : v;
            end else if (c == CH_SEMI) begin
                prm_idx++;
                if (prm_idx >= NPRM) prm_idx = NPRM - 1;
                prm[prm_idx] = 0;
            end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
                prm_idx = k + 1;
                do_command(c);
                esc_phase = PH_TEXT;
            end else if (c != CH_QMARK) begin
                esc_phase = PH_TEXT;
            end
            return 1;
        end
        esc_phase = PH_TEXT;
        if (c == CH_ESC) begin
            esc_phase = PH_ESC;
            return 1;
        end
        return 0;
    endfunction

    function automatic void write_byte(logic [7:0] c);
        int cols, spaces;
        cols = cols_now();
        if (take_escape(c)) return;
        if (c == CH_LF) begin
            next_line();
        end else if (c == CH_CR) begin
            cur_x = 0;
        end else if (c == CH_TAB) begin
            spaces = TABW - (cur_x % TABW);
            for (int i = 0; i < spaces && cur_x < cols; i++) begin
                void'(take_escape(CH_SP));
                put_glyph(CH_SP);
            end
        end else if (c == CH_BS) begin
            if (cur_x > 0) begin
                cur_x--;
                for (int i = cur_x; i + 1 < cols; i++) scr[cur_y][i] = scr[cur_y][i + 1];
                scr[cur_y][cols - 1] = '0;
            end
        end else begin
            put_glyph(c);
        end
    endfunction

    function automatic void predict_item(t_in_item it);
        t_out_item r;
        logic [15:0] v;
        r.cell_value = '0;
        if (cur_x >= cols_now()) cur_x = cols_now() - 1;
        if (cur_y >= rows_now()) cur_y = rows_now() - 1;
        case (it.op)
            OP_PUT: begin
                if (it.char_code == CH_LF && mode_cr) write_byte(CH_CR);
                write_byte(it.char_code);
            end
            OP_READ: begin
                v = scr[it.read_row][it.read_col];
                r.cell_value = v != 0 ? v : {attr, CH_SP};
            end
            OP_CLEAR: wipe_screen();
            default: ;
        endcase
        r.cursor_col = cur_x[6:0];
        r.cursor_row = cur_y[5:0];
        r.current_attr = attr;
        exp_q.push_back(r);
    endfunction

    function automatic void apply_cfg(t_cfg_item w);
        case (w.reg_index)
            CFG_DEFAULT_ATTR: mode_attr = w.wdata;
            CFG_ACTIVE_COLS:  mode_cols = w.wdata;
            CFG_ACTIVE_ROWS:  mode_rows = w.wdata[6:0];
            default:          mode_cr = w.wdata[0];
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // input and config driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data <= '0;
            cfg_if.valid <= 1'b0;
            cfg_if.data <= '0;
        end else begin
            if (in_if.valid && in_if.ready) predict_item(in_if.data);
            if (!in_if.valid || in_if.ready) begin
                if (item_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    in_if.valid <= 1'b1;
                    in_if.data <= item_q.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            if (cfg_if.valid && cfg_if.ready) apply_cfg(cfg_if.data);
            if (!cfg_if.valid || cfg_if.ready) begin
                if (cfg_q.size() > 0) begin
                    cfg_if.valid <= 1'b1;
                    cfg_if.data <= cfg_q.pop_front();
                end else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (exp_q.size() == 0) begin
                    $error("unexpected result %h", out_if.data);
                    fail_cnt++;
                end else begin
                    want = exp_q.pop_front();
                    if (out_if.data.cell_value !== want.cell_value) begin
                        $error("cell_value exp %h got %h", want.cell_value,
                               out_if.data.cell_value);
                        fail_cnt++;
                    end
                    if (out_if.data.cursor_col !== want.cursor_col) begin
                        $error("cursor_col exp %0d got %0d", want.cursor_col,
                               out_if.data.cursor_col);
                        fail_cnt++;
                    end
                    if (out_if.data.cursor_row !== want.cursor_row) begin
                        $error("cursor_row exp %0d got %0d", want.cursor_row,
                               out_if.data.cursor_row);
                        fail_cnt++;
                    end
                    if (out_if.data.current_attr !== want.current_attr) begin
                        $error("current_attr exp %h got %h", want.current_attr,
                               out_if.data.current_attr);
                        fail_cnt++;
                    end
                end
            end
            out_if.ready <= $urandom_range(99) >= recv_idle;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_MAX) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    int n_items;

    task automatic push_item(logic [1:0] op, logic [7:0] ch, logic [5:0] rr, logic [6:0] rc);
        t_in_item it;
        it.op = op;
        it.char_code = ch;
        it.read_row = rr;
        it.read_col = rc;
        item_q.push_back(it);
        n_items++;
    endtask

    task automatic put_byte(logic [7:0] ch);
        push_item(OP_PUT, ch, 6'($urandom_range(63)), 7'($urandom_range(127)));
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic read_cell(int rr, int rc);
        push_item(OP_READ, 8'($urandom_range(255)), 6'(rr), 7'(rc));
    endtask

    task automatic gen_escape();
        logic [7:0] fin;
        int np, num;
        logic [7:0] finals [0:9] = '{CMD_UP, CMD_DOWN, CMD_RIGHT, CMD_LEFT, CMD_POS,
                                     CMD_POS_F, CMD_ED, CMD_EL, CMD_SGR, "z"};
        int sgr_codes [0:7] = '{0, 1, 30, 37, 40, 47, 90, 5};
        put_byte(CH_ESC);
        if ($urandom_range(9) == 0) begin
            put_byte(8'($urandom_range(255)));
            return;
        end
        put_byte(CH_LBRK);
        if ($urandom_range(7) == 0) put_byte(CH_QMARK);
        fin = finals[$urandom_range(9)];
        np = $urandom_range(19) == 0 ? 18 : $urandom_range(3);
        for (int i = 0; i < np; i++) begin
            if (i > 0) put_byte(CH_SEMI);
            if (fin == CMD_SGR) num = $urandom_range(1) ? sgr_codes[$urandom_range(7)]
                                                       : $urandom_range(30, 97);
            else if (fin == CMD_ED) num = $urandom_range(2) ? 2 : $urandom_range(3);
            else if ($urandom_range(9) == 0) num = 99999;
            else if ($urandom_range(7) == 0) num = -1;
            else num = $urandom_range(cols_now() + 3);
            if (num >= 0) put_text($sformatf("%0d", num));
        end
        if ($urandom_range(9) == 0) put_byte("!");
        else put_byte(fin);
    endtask

    task automatic gen_random();
        int r;
        logic [7:0] ctl [0:3] = '{CH_LF, CH_CR, CH_TAB, CH_BS};
        r = $urandom_range(99);
        if (r < 38) put_byte(8'($urandom_range(32, 126)));
        else if (r < 48) put_byte(ctl[$urandom_range(3)]);
        else if (r < 68) gen_escape();
        else if (r < 74) put_byte(8'($urandom_range(255)));
        else if (r < 88) begin
            if ($urandom_range(3) == 0) read_cell($urandom_range(63), $urandom_range(127));
            else read_cell($urandom_range(rows_now() - 1), $urandom_range(cols_now() - 1));
        end else if (r < 91) push_item(OP_SPARE, 8'($urandom_range(255)),
                                       6'($urandom_range(63)), 7'($urandom_range(127)));
        else if (r < 92) push_item(OP_CLEAR, 8'($urandom_range(255)),
                                   6'($urandom_range(63)), 7'($urandom_range(127)));
        else put_byte(8'($urandom_range(32, 126)));
    endtask

    task automatic drain();
        wait (item_q.size() == 0 && !in_if.valid && exp_q.size() == 0
              && cfg_q.size() == 0 && !cfg_if.valid);
        @(posedge i_clk);
    endtask

    task automatic set_mode(logic [7:0] da, logic [7:0] cols, logic [7:0] rows, logic cr);
        drain();
        cfg_q.push_back('{CFG_DEFAULT_ATTR, da});
        cfg_q.push_back('{CFG_ACTIVE_COLS, cols});
        cfg_q.push_back('{CFG_ACTIVE_ROWS, rows});
        cfg_q.push_back('{CFG_ADD_CR, {7'd0, cr}});
        drain();
    endtask

    task automatic run_random(int count, int s_idle, int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        n_items = 0;
        while (n_items < count / 2) gen_random();
        drain();
        while (n_items < count) gen_random();
    endtask

    initial begin
        fail_cnt = 0;
        stall_cnt = 0;
        send_idle = 12;
        recv_idle = 83;
        wipe_screen();
        attr = ATTR_RESET;
        esc_phase = PH_TEXT;
        prm_idx = 0;
        for (int i = 0; i < NPRM; i++) prm[i] = 0;
        mode_attr = RST_DEFAULT_ATTR;
        mode_cols = RST_ACTIVE_COLS;
        mode_rows = RST_ACTIVE_ROWS;
        mode_cr = RST_ADD_CR;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_text("A\tB");
        put_byte(CH_BS);
        put_byte(CH_LF);
        put_byte(CH_ESC);
        put_text("[3;79H");
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(CH_ESC);
        put_text("[1;31;44;93m");
        put_byte(CH_ESC);
        put_text("[K");
        read_cell(0, 0);
        read_cell(63, 127);
        push_item(OP_SPARE, 8'h41, 6'd0, 7'd0);
        push_item(OP_CLEAR, 8'h00, 6'd0, 7'd0);

        set_mode(8'h1F, 8'd20, 8'd5, 1'b0);
        run_random(150, 12, 83);
        set_mode(8'h00, 8'd1, 8'd1, 1'b1);
        run_random(40, 12, 83);
        set_mode(8'hFF, 8'd128, 8'd64, 1'b0);
        run_random(60, 83, 12);
        set_mode(8'h5A, 8'd0, 8'd0, 1'b1);
        run_random(20, 83, 12);
        set_mode(8'h07, 8'd255, 8'd127, 1'b1);
        run_random(30, 0, 0);
        set_mode(8'h3C, 8'd33, 8'd7, 1'b0);
        run_random(150, 0, 0);

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
